@@ design/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants of the console line tokenizer: item layouts,
// parse modes, result kinds and character codes.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int BUFFER_BYTES_DEF = 256;
    localparam int MAX_TOKENS_DEF   = 16;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_PLAIN,
        MODE_PLAIN_QUOTED,
        MODE_OPEN,
        MODE_HELD
    } t_mode;

    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic [3:0] token_index;
        logic [4:0] token_total;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  res1;
        t_out_item  res0;
    } t_step;

endpackage

@@ design/console_line_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// console_line_tokenizer_core
// Splits a console command line, one byte per item, into token bytes,
// token-end marks and a line-done result with the token count.
// Path: each accepted item is registered, parsed, and its results are written into the result queue.
// Throughput: one item per cycle while each gives at most one result and the output
// is ready; an item with two results holds the single output port until both are taken.
// Reset: synchronous, active low; clears parse state, input and result queue.
// ----------------------------------------------------------------------------
module console_line_tokenizer_core #(
    parameter int BUFFER_BYTES = clt_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_TOKENS   = clt_pkg::MAX_TOKENS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clt_pkg::t_out_item o_out_item
);
    import clt_pkg::*;

    localparam int BW = $clog2(BUFFER_BYTES + 1);
    localparam int TW = $clog2(MAX_TOKENS + 1);

    logic          r_in_vld;
    t_in_item      r_in;
    t_mode         r_mode;
    logic [BW-1:0] r_bytes_used;
    logic [TW-1:0] r_token_count;

    t_mode         n_mode;
    logic [BW-1:0] n_bytes_used;
    logic [TW-1:0] n_token_count;
    t_step         step;
    logic [1:0]    space;
    logic          process;

    clt_parse #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_TOKENS   (MAX_TOKENS),
        .BW           (BW),
        .TW           (TW)
    ) u_parse (
        .i_mode        (r_mode),
        .i_bytes_used  (r_bytes_used),
        .i_token_count (r_token_count),
        .i_item        (r_in),
        .o_mode        (n_mode),
        .o_bytes_used  (n_bytes_used),
        .o_token_count (n_token_count),
        .o_step        (step)
    );

    clt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (process ? step.count : 2'd0),
        .i_res0   (step.res0),
        .i_res1   (step.res1),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item),
        .o_space  (space)
    );

    assign process    = r_in_vld && (step.count <= space);
    assign o_in_ready = !r_in_vld || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_mode        <= MODE_SKIP;
            r_bytes_used  <= '0;
            r_token_count <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (process) begin
                r_mode        <= n_mode;
                r_bytes_used  <= n_bytes_used;
                r_token_count <= n_token_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    a_token_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token_count <= TW'(MAX_TOKENS))
        else $error("token count past limit");

    a_buffer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_used <= BW'(BUFFER_BYTES))
        else $error("buffer use past capacity");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == KIND_DONE) |-> o_out_item.run_last)
        else $error("line done is not the last result of its item");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_in.command == CMD_EOL) |=>
            (r_mode == MODE_SKIP && r_token_count == '0 && r_bytes_used == '0))
        else $error("end of line did not return to reset state");

endmodule

@@ design/clt_parse.sv @@
// ----------------------------------------------------------------------------
// clt_parse
// Next-state and result logic for one line item: tracks the parse mode,
// buffer use and token count, and forms up to two result items.
// ----------------------------------------------------------------------------
module clt_parse #(
    parameter int BUFFER_BYTES = clt_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_TOKENS   = clt_pkg::MAX_TOKENS_DEF,
    parameter int BW           = $clog2(BUFFER_BYTES + 1),
    parameter int TW           = $clog2(MAX_TOKENS + 1)
) (
    input  clt_pkg::t_mode    i_mode,
    input  logic [BW-1:0]     i_bytes_used,
    input  logic [TW-1:0]     i_token_count,
    input  clt_pkg::t_in_item i_item,
    output clt_pkg::t_mode    o_mode,
    output logic [BW-1:0]     o_bytes_used,
    output logic [TW-1:0]     o_token_count,
    output clt_pkg::t_step    o_step
);
    import clt_pkg::*;

    function automatic t_out_item mk_res(input logic [1:0] kind, input logic [7:0] b,
                                         input logic [6:0] idx, input logic [6:0] tot);
        t_out_item r;
        r.result_kind = kind;
        r.out_byte    = b;
        r.token_index = idx[3:0];
        r.token_total = tot[4:0];
        r.run_last    = 1'b0;
        return r;
    endfunction

    t_mode         mode;
    logic [BW-1:0] bu;
    logic [TW-1:0] tc;
    logic [1:0]    n;
    t_out_item     res [2];
    logic [7:0]    b;
    logic          ws;

    always_comb begin
        mode   = i_mode;
        bu     = i_bytes_used;
        tc     = i_token_count;
        n      = 2'd0;
        res[0] = mk_res(KIND_BYTE, 8'd0, 7'd0, 7'd0);
        res[1] = mk_res(KIND_BYTE, 8'd0, 7'd0, 7'd0);
        b      = i_item.in_byte;
        ws     = (b inside {CH_SPACE, CH_TAB});

        if (i_item.command == CMD_EOL) begin
            if (mode inside {MODE_PLAIN, MODE_PLAIN_QUOTED, MODE_OPEN, MODE_HELD}) begin
                if (bu < BW'(BUFFER_BYTES)) begin
                    bu = bu + 1'b1;
                end
                res[n[0]] = mk_res(KIND_END, 8'd0, 7'(tc), 7'd0);
                n  = n + 2'd1;
                tc = tc + 1'b1;
            end
            res[n[0]] = mk_res(KIND_DONE, 8'd0, 7'd0, 7'(tc));
            n    = n + 2'd1;
            mode = MODE_SKIP;
            bu   = '0;
            tc   = '0;
        end else begin
            case (mode)
                MODE_PLAIN, MODE_PLAIN_QUOTED: begin
                    if (b == CH_QUOTE) begin
                        mode = (mode == MODE_PLAIN) ? MODE_PLAIN_QUOTED : MODE_PLAIN;
                    end else if (mode == MODE_PLAIN && ws) begin
                        if (bu < BW'(BUFFER_BYTES)) begin
                            bu = bu + 1'b1;
                        end
                        res[n[0]] = mk_res(KIND_END, 8'd0, 7'(tc), 7'd0);
                        n    = n + 2'd1;
                        tc   = tc + 1'b1;
                        mode = MODE_SKIP;
                    end else if (bu < BW'(BUFFER_BYTES - 1)) begin
                        bu = bu + 1'b1;
                        res[n[0]] = mk_res(KIND_BYTE, b, 7'(tc), 7'd0);
                        n  = n + 2'd1;
                    end
                end
                MODE_OPEN: begin
                    if (b == CH_QUOTE) begin
                        mode = MODE_HELD;
                    end else if (bu < BW'(BUFFER_BYTES - 1)) begin
                        bu = bu + 1'b1;
                        res[n[0]] = mk_res(KIND_BYTE, b, 7'(tc), 7'd0);
                        n  = n + 2'd1;
                    end
                end
                MODE_HELD: begin
                    if (ws) begin
                        if (bu < BW'(BUFFER_BYTES)) begin
                            bu = bu + 1'b1;
                        end
                        res[n[0]] = mk_res(KIND_END, 8'd0, 7'(tc), 7'd0);
                        n    = n + 2'd1;
                        tc   = tc + 1'b1;
                        mode = MODE_SKIP;
                    end else begin
                        if (bu < BW'(BUFFER_BYTES - 1)) begin
                            bu = bu + 1'b1;
                            res[n[0]] = mk_res(KIND_BYTE, CH_QUOTE, 7'(tc), 7'd0);
                            n  = n + 2'd1;
                        end
                        if (b == CH_QUOTE) begin
                            mode = MODE_HELD;
                        end else begin
                            if (bu < BW'(BUFFER_BYTES - 1)) begin
                                bu = bu + 1'b1;
                                res[n[0]] = mk_res(KIND_BYTE, b, 7'(tc), 7'd0);
                                n  = n + 2'd1;
                            end
                            mode = MODE_OPEN;
                        end
                    end
                end
                default: begin
                    mode = MODE_SKIP;
                    if (!ws && tc < TW'(MAX_TOKENS) && bu < BW'(BUFFER_BYTES)) begin
                        if (b == CH_QUOTE) begin
                            mode = MODE_OPEN;
                        end else begin
                            mode = MODE_PLAIN;
                            if (bu < BW'(BUFFER_BYTES - 1)) begin
                                bu = bu + 1'b1;
                                res[n[0]] = mk_res(KIND_BYTE, b, 7'(tc), 7'd0);
                                n  = n + 2'd1;
                            end
                        end
                    end
                end
            endcase
        end

        if (n == 2'd2) begin
            res[1].run_last = 1'b1;
        end else if (n == 2'd1) begin
            res[0].run_last = 1'b1;
        end

        o_mode        = mode;
        o_bytes_used  = bu;
        o_token_count = tc;
        o_step.count  = n;
        o_step.res0   = res[0];
        o_step.res1   = res[1];
    end

endmodule

@@ design/clt_outq.sv @@
// ----------------------------------------------------------------------------
// clt_outq
// Two-entry result queue: takes up to two result items per cycle and
// presents them one per cycle on the output channel while it is ready.
// ----------------------------------------------------------------------------
module clt_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_n,
    input  clt_pkg::t_out_item i_res0,
    input  clt_pkg::t_out_item i_res1,
    input  logic               i_ready,
    output logic               o_valid,
    output clt_pkg::t_out_item o_item,
    output logic [1:0]         o_space
);
    import clt_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_out_item  r_q [2];
    t_out_item  n_q [2];
    logic       pop;
    logic [1:0] base;

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[0];
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - {1'b0, pop};
    assign o_space = 2'd2 - base;

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        case (base)
            2'd0: begin
                if (i_push_n != 2'd0) begin
                    n_q[0] = i_res0;
                end
                if (i_push_n == 2'd2) begin
                    n_q[1] = i_res1;
                end
            end
            2'd1: begin
                if (i_push_n != 2'd0) begin
                    n_q[1] = i_res0;
                end
            end
            default: begin
            end
        endcase
        n_cnt = base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule

@@ sim/console_line_tokenizer_core_tb.sv @@
// ----------------------------------------------------------------------------
// console_line_tokenizer_core_tb
// Feeds command lines, one character item at a time and closed by an
// end-of-line item, into the tokenizer. A behavioral tokenizer works out the
// token bytes, token-end marks and line-done counts for every accepted item,
// and each result leaving the block is checked field by field in order.
// Directed lines open the run, then random lines follow under changing
// backpressure.
// ----------------------------------------------------------------------------
module console_line_tokenizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clt_pkg::*;

    localparam int BUF_SLOTS    = BUFFER_BYTES_DEF;
    localparam int TOKEN_CAP    = MAX_TOKENS_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_LINE    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 20;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_line_char;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_line_char char_q[$];
    t_out_item  token_results_q[$];
    t_out_item  want_result;

    t_mode       scan_mode   = MODE_SKIP;
    int unsigned slots_used  = 0;
    int unsigned tokens_seen = 0;
    t_out_item   last_result;
    bit          have_last;

    bit drain_next   = 1'b0;
    bit in_taken     = 1'b0;
    int rst_count    = 0;
    int n_cycles     = 0;
    int n_taken      = 0;
    int n_chars_total = 0;
    int n_mismatch   = 0;

    console_line_tokenizer_core #(
        .BUFFER_BYTES(BUF_SLOTS),
        .MAX_TOKENS  (TOKEN_CAP)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_blank(logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB;
    endfunction

    function void queue_result(logic [1:0] kind, logic [7:0] ch, logic [3:0] idx,
                               logic [4:0] total);
        if (have_last)
            token_results_q.push_back(last_result);
        last_result = '{result_kind: kind, out_byte: ch, token_index: idx,
                        token_total: total, run_last: 1'b0};
        have_last = 1'b1;
    endfunction

    function void keep_char(logic [7:0] ch);
        if (slots_used + 1 < BUF_SLOTS) begin
            slots_used++;
            queue_result(KIND_BYTE, ch, tokens_seen[3:0], 5'd0);
        end
    endfunction

    function void close_token();
        if (slots_used < BUF_SLOTS)
            slots_used++;
        queue_result(KIND_END, 8'h00, tokens_seen[3:0], 5'd0);
        tokens_seen++;
        scan_mode = MODE_SKIP;
    endfunction

    function void predict_tokens(t_in_item it);
        have_last = 1'b0;
        if (it.command == CMD_EOL) begin
            if (scan_mode != MODE_SKIP)
                close_token();
            queue_result(KIND_DONE, 8'h00, 4'd0, tokens_seen[4:0]);
            scan_mode   = MODE_SKIP;
            slots_used  = 0;
            tokens_seen = 0;
        end else begin
            case (scan_mode)
                MODE_PLAIN, MODE_PLAIN_QUOTED: begin
                    if (it.in_byte == CH_QUOTE) begin
                        if (scan_mode == MODE_PLAIN)
                            scan_mode = MODE_PLAIN_QUOTED;
                        else
                            scan_mode = MODE_PLAIN;
                    end else if (scan_mode == MODE_PLAIN && is_blank(it.in_byte)) begin
                        close_token();
                    end else begin
                        keep_char(it.in_byte);
                    end
                end
                MODE_OPEN: begin
                    if (it.in_byte == CH_QUOTE)
                        scan_mode = MODE_HELD;
                    else
                        keep_char(it.in_byte);
                end
                MODE_HELD: begin
                    if (is_blank(it.in_byte)) begin
                        close_token();
                    end else begin
                        keep_char(CH_QUOTE);
                        if (it.in_byte != CH_QUOTE) begin
                            keep_char(it.in_byte);
                            scan_mode = MODE_OPEN;
                        end
                    end
                end
                default: begin
                    scan_mode = MODE_SKIP;
                    if (!is_blank(it.in_byte) && tokens_seen < TOKEN_CAP &&
                        slots_used < BUF_SLOTS) begin
                        if (it.in_byte == CH_QUOTE) begin
                            scan_mode = MODE_OPEN;
                        end else begin
                            scan_mode = MODE_PLAIN;
                            keep_char(it.in_byte);
                        end
                    end
                end
            endcase
        end
        if (have_last) begin
            last_result.run_last = 1'b1;
            token_results_q.push_back(last_result);
        end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_mismatch++;
        end
    endfunction

    function automatic int unsigned idle_pct(bit rx);
        if (n_taken * 3 < n_chars_total)
            return rx ? 72 : 7;
        else if (n_taken * 3 < n_chars_total * 2)
            return rx ? 7 : 72;
        return 0;
    endfunction

    function void push_item(logic cmd, logic [7:0] ch);
        t_line_char c;
        c.item.command = cmd;
        c.item.in_byte = ch;
        c.drain        = drain_next;
        drain_next     = 1'b0;
        char_q.push_back(c);
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] ch;
        if ($urandom_range(0, 3) != 0)
            return 8'h61 + 8'($urandom_range(0, 25));
        do
            ch = 8'($urandom);
        while (ch == CH_SPACE || ch == CH_TAB || ch == CH_QUOTE);
        return ch;
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    always @(negedge i_clk) begin
        if (rst_count < 6) begin
            rst_count++;
            i_rst_n <= 1'b0;
        end else begin
            i_rst_n <= 1'b1;
            if (!i_in_valid || in_taken) begin
                if (char_q.size() != 0 && !(char_q[0].drain && token_results_q.size() != 0)
                    && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= char_q[0].item;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= $urandom_range(0, 99) >= idle_pct(1'b1);
        end
        in_taken = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("console_line_tokenizer_core_tb NOT OK");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_tokens(i_in_item);
                void'(char_q.pop_front());
                n_taken++;
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (token_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, o_out_item);
                    n_mismatch++;
                end else begin
                    want_result = token_results_q.pop_front();
                    check_field("result_kind", 8'(want_result.result_kind),
                                8'(o_out_item.result_kind));
                    check_field("out_byte", want_result.out_byte, o_out_item.out_byte);
                    check_field("token_index", 8'(want_result.token_index),
                                8'(o_out_item.token_index));
                    check_field("token_total", 8'(want_result.token_total),
                                8'(o_out_item.token_total));
                    check_field("run_last", 8'(want_result.run_last),
                                8'(o_out_item.run_last));
                end
            end
        end
    end

    initial begin
        int  kind;
        int  n_tok;
        int  len;
        int  i;
        int  random_start;
        bit  long_done;

        // quoted section in a plain token, zero byte, held quote cases
        push_item(CMD_CHAR, CH_SPACE);
        push_item(CMD_CHAR, "a");
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_CHAR, "b");
        push_item(CMD_CHAR, CH_SPACE);
        push_item(CMD_CHAR, "c");
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_CHAR, 8'h00);
        push_item(CMD_CHAR, CH_TAB);
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_CHAR, "x");
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_CHAR, "y");
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_CHAR, CH_SPACE);
        push_item(CMD_CHAR, 8'hFF);
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_EOL, 8'hFF);
        // empty line
        push_item(CMD_EOL, 8'h00);
        // held quote closed by the line end
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_CHAR, "q");
        push_item(CMD_CHAR, CH_QUOTE);
        push_item(CMD_EOL, CH_QUOTE);

        drain_next   = 1'b1;
        long_done    = 1'b0;
        random_start = char_q.size();
        while (char_q.size() - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                drain_next = 1'b1;
            if (!long_done && char_q.size() - random_start > RANDOM_ITEMS / 2)
                kind = 100;
            else
                kind = $urandom_range(0, 99);

            if (kind == 100) begin
                // overflow the token buffer
                long_done = 1'b1;
                len = 0;
                while (len < LONG_LINE) begin
                    n_tok = $urandom_range(20, 80);
                    repeat (n_tok) push_item(CMD_CHAR, word_char());
                    push_item(CMD_CHAR, blank_char());
                    len += n_tok + 1;
                end
            end else if (kind < 65) begin
                if ($urandom_range(0, 3) == 0)
                    push_item(CMD_CHAR, blank_char());
                n_tok = $urandom_range(1, 6);
                for (i = 0; i < n_tok; i++) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            repeat ($urandom_range(1, 8)) push_item(CMD_CHAR, word_char());
                        end
                        1: begin
                            repeat ($urandom_range(0, 3)) push_item(CMD_CHAR, word_char());
                            push_item(CMD_CHAR, CH_QUOTE);
                            repeat ($urandom_range(1, 5))
                                push_item(CMD_CHAR, ($urandom_range(0, 2) == 0) ?
                                          blank_char() : word_char());
                            if ($urandom_range(0, 4) != 0)
                                push_item(CMD_CHAR, CH_QUOTE);
                            repeat ($urandom_range(0, 3)) push_item(CMD_CHAR, word_char());
                        end
                        default: begin
                            push_item(CMD_CHAR, CH_QUOTE);
                            repeat ($urandom_range(0, 6)) begin
                                case ($urandom_range(0, 5))
                                    0: push_item(CMD_CHAR, blank_char());
                                    1: begin
                                        push_item(CMD_CHAR, CH_QUOTE);
                                        push_item(CMD_CHAR, word_char());
                                    end
                                    2: begin
                                        push_item(CMD_CHAR, CH_QUOTE);
                                        push_item(CMD_CHAR, CH_QUOTE);
                                    end
                                    default: push_item(CMD_CHAR, word_char());
                                endcase
                            end
                            if ($urandom_range(0, 4) != 0)
                                push_item(CMD_CHAR, CH_QUOTE);
                        end
                    endcase
                    if (i != n_tok - 1 || $urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 2)) push_item(CMD_CHAR, blank_char());
                end
            end else if (kind < 85) begin
                repeat ($urandom_range(0, 20)) begin
                    case ($urandom_range(0, 5))
                        0: push_item(CMD_CHAR, CH_QUOTE);
                        1: push_item(CMD_CHAR, blank_char());
                        default: push_item(CMD_CHAR, 8'($urandom));
                    endcase
                end
            end else begin
                // token counts from just under the limit to past it
                repeat ($urandom_range(TOKEN_CAP - 1, TOKEN_CAP + 6)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_item(CMD_CHAR, CH_QUOTE);
                        push_item(CMD_CHAR, word_char());
                        push_item(CMD_CHAR, CH_QUOTE);
                    end else begin
                        push_item(CMD_CHAR, word_char());
                    end
                    push_item(CMD_CHAR, blank_char());
                end
            end
            push_item(CMD_EOL, 8'($urandom));
        end
        n_chars_total = char_q.size();

        while (char_q.size() != 0 || token_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (n_mismatch == 0 && token_results_q.size() == 0)
            $display("console_line_tokenizer_core_tb OK");
        else
            $display("console_line_tokenizer_core_tb NOT OK");
        $finish;
    end

endmodule
